@@ hdl/assert_macros.svh @@
// assertion macros shared by the scheduler rtl
// depends on nothing; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checks are off while reset is high
`define CTS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scheduler check failed");

// next-cycle implication, checks are off while reset is high
`define CTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scheduler check failed");

`endif

@@ hdl/cts_pkg.sv @@
// shared types, codes and helpers of the cooperative thread scheduler
// no dependencies; imported by the scheduler top level and cts_step
`default_nettype none

package cts_pkg;

   localparam int MAX_THREADS = 64;
   localparam int MAX_SEMS    = 16;

   localparam int TID_W  = 7;
   localparam int TIDX_W = $clog2(MAX_THREADS);
   localparam int FILL_W = $clog2(MAX_THREADS + 1);
   localparam int SID_W  = 5;
   localparam int SIDX_W = (MAX_SEMS > 1) ? $clog2(MAX_SEMS) : 1;
   localparam int SCNT_W = $clog2(MAX_SEMS + 1);
   localparam int CNT_W  = 17;
   localparam int INIT_W = 16;

   localparam logic signed [CNT_W-1:0] CNT_MAX = CNT_W'(65535);
   localparam logic signed [CNT_W-1:0] CNT_MIN = CNT_W'(-65536);

   // command codes
   localparam logic [3:0] OP_START   = 4'd0;
   localparam logic [3:0] OP_CREATE  = 4'd1;
   localparam logic [3:0] OP_YIELD   = 4'd2;
   localparam logic [3:0] OP_EXIT    = 4'd3;
   localparam logic [3:0] OP_JOIN    = 4'd4;
   localparam logic [3:0] OP_JOINALL = 4'd5;
   localparam logic [3:0] OP_SEMINIT = 4'd6;
   localparam logic [3:0] OP_SIGNAL  = 4'd7;
   localparam logic [3:0] OP_WAIT    = 4'd8;
   localparam logic [3:0] OP_DESTROY = 4'd9;

   // result status codes
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_REFUSED  = 3'd1;
   localparam logic [2:0] ST_NOSEM    = 3'd2;
   localparam logic [2:0] ST_DEADLOCK = 3'd3;
   localparam logic [2:0] ST_FULL     = 3'd4;

   // thread states
   localparam logic [2:0] TS_READY   = 3'd1;
   localparam logic [2:0] TS_RUN     = 3'd2;
   localparam logic [2:0] TS_JOIN    = 3'd3;
   localparam logic [2:0] TS_DEAD    = 3'd4;
   localparam logic [2:0] TS_SEMWAIT = 3'd5;
   localparam logic [2:0] TS_JOINALL = 3'd6;

   // request to the shared saturating step unit
   typedef struct packed {
      logic signed [CNT_W-1:0] a;
      logic                    up;
      logic                    floor_zero;
   } step_req_type;

   // table row of a thread identifier
   function automatic logic [TIDX_W-1:0] tidx(input logic [TID_W-1:0] id);
      logic [TID_W-1:0] d;
      d = id - 1'b1;
      return d[TIDX_W-1:0];
   endfunction

endpackage

`default_nettype wire

@@ hdl/cts_ram.sv @@
// simple dual-port table memory, one write and one registered read per cycle
// no dependencies; instantiated by the scheduler top level
`default_nettype none

module cts_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 7
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // registered read, new data when the same row is written
   always_ff @(posedge clock) begin
      if (we && (waddr == raddr)) begin
         rdata <= wdata;
      end else begin
         rdata <= mem[raddr];
      end
   end

endmodule

`default_nettype wire

@@ hdl/cts_step.sv @@
// shared saturating increment and decrement unit for the table and semaphore counters
// depends on cts_pkg
`default_nettype none

module cts_step
   import cts_pkg::*;
(
   input  wire step_req_type             req,
   output logic signed [CNT_W-1:0]       y
);

   // up saturates at the top, down stops at zero or at the bottom
   always_comb begin
      if (req.up) begin
         y = (req.a < CNT_MAX) ? req.a + 2'sd1 : req.a;
      end else if (req.floor_zero) begin
         y = (req.a != '0) ? req.a - 2'sd1 : req.a;
      end else begin
         y = (req.a > CNT_MIN) ? req.a - 2'sd1 : req.a;
      end
   end

endmodule

`default_nettype wire

@@ hdl/cooperative_thread_scheduler.sv @@
// Cooperative thread scheduler: thread table, FIFO ready queue and counting
// semaphores with FIFO wait lists, driven by one command per transfer.
//
// req channel: one command per transfer (op, target thread, semaphore index,
// initial count). rsp channel: one result per command (running thread, new id,
// status, idle flag). A command is taken only while the sequencer is idle;
// req_tready stays low until its result has been moved to the output register.
// From acceptance to rsp_tvalid a command passes through a decode state,
// a read-modify-write step on the thread tables for each table access
// (single read port per table, registered read), the states S_D1 and S_D2
// that pick the next thread from the ready queue, and S_RESP, which loads
// the result register. Start, sem_init, destroy and commands refused at decode
// go straight to S_RESP; a blocking join and an exit with a parent take the
// longest path. The next command can be taken in the cycle after the result is loaded.
// The result register holds while rsp_tready is low; the next command may be
// accepted meanwhile, but its result waits until the register is free.
// Reset clears the scheduler's counters, the ready queue and the result
// valid flag; the tables need no clearing because every row is written when a
// thread or semaphore is made.
// Depends on cts_pkg, cts_ram, cts_step and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module cooperative_thread_scheduler
   import cts_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [3:0] op, [10:4] target_thread, [15:11] sem_index, [31:16] initial_count
   input  wire logic [31:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [6:0] running_thread, [13:7] new_id, [16:14] status, [17] idle, rest zero
   output logic [23:0]      rsp_tdata
);

   typedef enum logic [4:0] {
      S_IDLE, S_DEC, S_CREATE2, S_DP2, S_DP3, S_Y, S_E1, S_E2, S_E3,
      S_J1, S_J2, S_J3, S_JA1, S_JA2, S_SIG2, S_W2, S_D1, S_D2, S_RESP
   } seq_type;

   seq_type                  state_ff, state_in;
   logic [3:0]               op_ff, op_in;
   logic [TID_W-1:0]         tgt_ff, tgt_in;
   logic [SID_W-1:0]         si_ff, si_in;
   logic signed [INIT_W-1:0] init_ff, init_in;
   logic [TID_W-1:0]         cur_ff, cur_in;
   logic [TID_W-1:0]         made_ff, made_in;
   logic [SCNT_W-1:0]        sems_made_ff, sems_made_in;
   logic [SCNT_W-1:0]        live_sems_ff, live_sems_in;
   logic [TIDX_W-1:0]        head_ff, head_in;
   logic [FILL_W-1:0]        fill_ff, fill_in;
   logic [TID_W-1:0]         p_ff, p_in;
   logic [TID_W-1:0]         aux_ff, aux_in;
   logic [TID_W-1:0]         hold_ff, hold_in;
   logic                     wake_ff, wake_in;
   logic                     decw_ff, decw_in;
   logic                     clrblk_ff, clrblk_in;
   logic                     tgt_ok_ff, tgt_ok_in;
   logic [2:0]               status_ff, status_in;
   logic [TID_W-1:0]         nid_ff, nid_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [TID_W-1:0]         rsp_run_ff;
   logic [TID_W-1:0]         rsp_nid_ff;
   logic [2:0]               rsp_st_ff;
   logic                     rsp_load;

   // semaphore table, one row written per cycle
   logic signed [CNT_W-1:0]  sem_count_ff [MAX_SEMS];
   logic [TID_W-1:0]         sem_first_ff [MAX_SEMS];
   logic [TID_W-1:0]         sem_last_ff  [MAX_SEMS];
   logic                     sem_we;
   logic [SIDX_W-1:0]        sem_idx;
   logic signed [CNT_W-1:0]  sem_cnt_w;
   logic [TID_W-1:0]         sem_first_w;
   logic [TID_W-1:0]         sem_last_w;

   // thread table and queue memory ports
   logic                     ts_we, par_we, kid_we, blk_we, wtc_we, ring_we, wnx_we;
   logic [TIDX_W-1:0]        ts_wa, par_wa, kid_wa, blk_wa, wtc_wa, ring_wa, wnx_wa;
   logic [TIDX_W-1:0]        ts_ra, par_ra, kid_ra, blk_ra, wtc_ra, wnx_ra;
   logic [2:0]               ts_wd, ts_rd;
   logic [TID_W-1:0]         par_wd, par_rd, kid_wd, kid_rd, wtc_wd, wtc_rd;
   logic [TID_W-1:0]         ring_wd, ring_rd, wnx_wd, wnx_rd;
   logic                     blk_wd, blk_rd;

   // ready queue push request
   logic                     push_en;
   logic [TID_W-1:0]         push_id;
   logic [FILL_W:0]          ring_pos;

   step_req_type             step_req;
   logic signed [CNT_W-1:0]  step_y;

   logic                     req_fire;
   logic                     needs_thread;
   logic                     sem_op;
   logic [SIDX_W-1:0]        si_idx;
   logic [SID_W-1:0]         si_m1;
   seq_type                  post_dp;

   cts_ram #(.DEPTH(MAX_THREADS), .WIDTH(3)) u_state (
      .clock(clock), .we(ts_we), .waddr(ts_wa), .wdata(ts_wd), .raddr(ts_ra), .rdata(ts_rd));
   cts_ram #(.DEPTH(MAX_THREADS), .WIDTH(TID_W)) u_parent (
      .clock(clock), .we(par_we), .waddr(par_wa), .wdata(par_wd), .raddr(par_ra),
      .rdata(par_rd));
   cts_ram #(.DEPTH(MAX_THREADS), .WIDTH(TID_W)) u_kids (
      .clock(clock), .we(kid_we), .waddr(kid_wa), .wdata(kid_wd), .raddr(kid_ra),
      .rdata(kid_rd));
   cts_ram #(.DEPTH(MAX_THREADS), .WIDTH(1)) u_blocks (
      .clock(clock), .we(blk_we), .waddr(blk_wa), .wdata(blk_wd), .raddr(blk_ra),
      .rdata(blk_rd));
   cts_ram #(.DEPTH(MAX_THREADS), .WIDTH(TID_W)) u_waitc (
      .clock(clock), .we(wtc_we), .waddr(wtc_wa), .wdata(wtc_wd), .raddr(wtc_ra),
      .rdata(wtc_rd));
   cts_ram #(.DEPTH(MAX_THREADS), .WIDTH(TID_W)) u_ring (
      .clock(clock), .we(ring_we), .waddr(ring_wa), .wdata(ring_wd), .raddr(head_ff),
      .rdata(ring_rd));
   cts_ram #(.DEPTH(MAX_THREADS), .WIDTH(TID_W)) u_wnext (
      .clock(clock), .we(wnx_we), .waddr(wnx_wa), .wdata(wnx_wd), .raddr(wnx_ra),
      .rdata(wnx_rd));

   cts_step u_step (.req(step_req), .y(step_y));

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, (rsp_run_ff == '0), rsp_st_ff, rsp_nid_ff, rsp_run_ff};

   assign needs_thread = (op_ff inside {OP_CREATE, OP_YIELD, OP_EXIT, OP_JOIN,
                                        OP_JOINALL, OP_WAIT});
   assign sem_op       = (op_ff inside {OP_SIGNAL, OP_WAIT, OP_DESTROY});
   assign si_m1        = si_ff - 1'b1;
   assign si_idx       = si_m1[SIDX_W-1:0];

   // where a command goes once the dead parent link is settled
   always_comb begin
      case (op_ff)
         OP_YIELD: post_dp = S_Y;
         OP_EXIT:  post_dp = S_E1;
         OP_JOIN:  post_dp = S_J1;
         default:  post_dp = S_JA1;
      endcase
   end

   // command sequencer
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      tgt_in       = tgt_ff;
      si_in        = si_ff;
      init_in      = init_ff;
      cur_in       = cur_ff;
      made_in      = made_ff;
      sems_made_in = sems_made_ff;
      live_sems_in = live_sems_ff;
      head_in      = head_ff;
      fill_in      = fill_ff;
      p_in         = p_ff;
      aux_in       = aux_ff;
      hold_in      = hold_ff;
      wake_in      = wake_ff;
      decw_in      = decw_ff;
      clrblk_in    = clrblk_ff;
      tgt_ok_in    = tgt_ok_ff;
      status_in    = status_ff;
      nid_in       = nid_ff;
      rsp_load     = 1'b0;

      sem_we      = 1'b0;
      sem_idx     = si_idx;
      sem_cnt_w   = sem_count_ff[si_idx];
      sem_first_w = sem_first_ff[si_idx];
      sem_last_w  = sem_last_ff[si_idx];

      ts_we  = 1'b0; ts_wa  = '0; ts_wd  = '0; ts_ra  = '0;
      par_we = 1'b0; par_wa = '0; par_wd = '0; par_ra = '0;
      kid_we = 1'b0; kid_wa = '0; kid_wd = '0; kid_ra = '0;
      blk_we = 1'b0; blk_wa = '0; blk_wd = 1'b0; blk_ra = '0;
      wtc_we = 1'b0; wtc_wa = '0; wtc_wd = '0; wtc_ra = '0;
      wnx_we = 1'b0; wnx_wa = '0; wnx_wd = '0; wnx_ra = '0;
      push_en = 1'b0;
      push_id = '0;

      step_req.a          = '0;
      step_req.up         = 1'b1;
      step_req.floor_zero = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in     = req_tdata[3:0];
               tgt_in    = req_tdata[10:4];
               si_in     = req_tdata[15:11];
               init_in   = req_tdata[31:16];
               tgt_ok_in = (req_tdata[10:4] <= made_ff);
               status_in = ST_OK;
               nid_in    = '0;
               state_in  = S_DEC;
            end
         end

         S_DEC: begin
            state_in = S_RESP;
            if (sem_op && (live_sems_ff == '0)) begin
               status_in = ST_NOSEM;
            end else if (sem_op && ((si_ff == '0) || (si_ff > SID_W'(sems_made_ff)))) begin
               status_in = ST_REFUSED;
            end else if (needs_thread && (cur_ff == '0)) begin
               status_in = ST_REFUSED;
            end else begin
               case (op_ff)
                  OP_START: begin
                     if (made_ff != '0) begin
                        status_in = ST_REFUSED;
                     end else begin
                        ts_we = 1'b1;  ts_wd = TS_RUN;
                        par_we = 1'b1; kid_we = 1'b1; blk_we = 1'b1; wtc_we = 1'b1;
                        made_in = TID_W'(1);
                        head_in = '0;
                        fill_in = '0;
                        cur_in  = TID_W'(1);
                        nid_in  = TID_W'(1);
                     end
                  end
                  OP_CREATE: begin
                     if (made_ff >= TID_W'(MAX_THREADS)) begin
                        status_in = ST_FULL;
                     end else begin
                        ts_we = 1'b1;  ts_wa = made_ff[TIDX_W-1:0]; ts_wd = TS_READY;
                        par_we = 1'b1; par_wa = made_ff[TIDX_W-1:0]; par_wd = cur_ff;
                        kid_we = 1'b1; kid_wa = made_ff[TIDX_W-1:0];
                        blk_we = 1'b1; blk_wa = made_ff[TIDX_W-1:0];
                        wtc_we = 1'b1; wtc_wa = made_ff[TIDX_W-1:0];
                        kid_ra  = tidx(cur_ff);
                        push_en = 1'b1;
                        push_id = made_ff + 1'b1;
                        made_in = made_ff + 1'b1;
                        nid_in  = made_ff + 1'b1;
                        state_in = S_CREATE2;
                     end
                  end
                  OP_YIELD, OP_EXIT, OP_JOIN, OP_JOINALL: begin
                     par_ra   = tidx(cur_ff);
                     state_in = S_DP2;
                  end
                  OP_SEMINIT: begin
                     if (sems_made_ff >= SCNT_W'(MAX_SEMS)) begin
                        status_in = ST_FULL;
                     end else begin
                        sem_we       = 1'b1;
                        sem_idx      = sems_made_ff[SIDX_W-1:0];
                        sem_cnt_w    = CNT_W'(init_ff);
                        sem_first_w  = '0;
                        sem_last_w   = '0;
                        sems_made_in = sems_made_ff + 1'b1;
                        live_sems_in = live_sems_ff + 1'b1;
                        nid_in       = TID_W'(sems_made_ff + 1'b1);
                     end
                  end
                  OP_SIGNAL: begin
                     step_req.a  = sem_count_ff[si_idx];
                     step_req.up = 1'b1;
                     sem_we      = 1'b1;
                     sem_cnt_w   = step_y;
                     if ((step_y[CNT_W-1] || (step_y == '0)) &&
                         (sem_first_ff[si_idx] != '0)) begin
                        aux_in   = sem_first_ff[si_idx];
                        wnx_ra   = tidx(sem_first_ff[si_idx]);
                        state_in = S_SIG2;
                     end
                  end
                  OP_WAIT: begin
                     step_req.a  = sem_count_ff[si_idx];
                     step_req.up = 1'b0;
                     sem_we      = 1'b1;
                     sem_cnt_w   = step_y;
                     if (step_y[CNT_W-1]) begin
                        aux_in = sem_last_ff[si_idx];
                        wnx_we = 1'b1; wnx_wa = tidx(cur_ff); wnx_wd = '0;
                        if (sem_last_ff[si_idx] == '0) begin
                           sem_first_w = cur_ff;
                        end
                        sem_last_w = cur_ff;
                        ts_we = 1'b1; ts_wa = tidx(cur_ff); ts_wd = TS_SEMWAIT;
                        state_in = S_W2;
                     end
                  end
                  OP_DESTROY: begin
                     if (sem_first_ff[si_idx] == '0) begin
                        live_sems_in = live_sems_ff - 1'b1;
                     end else begin
                        status_in = ST_REFUSED;
                     end
                  end
                  default: begin
                     status_in = ST_REFUSED;
                  end
               endcase
            end
         end

         S_CREATE2: begin
            step_req.a  = CNT_W'(kid_rd);
            step_req.up = 1'b1;
            kid_we = 1'b1; kid_wa = tidx(cur_ff); kid_wd = step_y[TID_W-1:0];
            state_in = S_RESP;
         end

         // clear a parent link that points at a terminated thread
         S_DP2: begin
            p_in = par_rd;
            if (par_rd != '0) begin
               ts_ra    = tidx(par_rd);
               state_in = S_DP3;
            end else begin
               state_in = post_dp;
            end
         end

         S_DP3: begin
            if (ts_rd == TS_DEAD) begin
               par_we = 1'b1; par_wa = tidx(cur_ff); par_wd = '0;
               p_in   = '0;
            end
            state_in = post_dp;
         end

         S_Y: begin
            if ((cur_ff == TID_W'(1)) && (fill_ff == '0)) begin
               cur_in   = '0;
               state_in = S_RESP;
            end else begin
               push_en = 1'b1;
               push_id = cur_ff;
               ts_we = 1'b1; ts_wa = tidx(cur_ff); ts_wd = TS_READY;
               state_in = S_D1;
            end
         end

         // exit: mark dead, fetch parent bookkeeping
         S_E1: begin
            ts_we = 1'b1; ts_wa = tidx(cur_ff); ts_wd = TS_DEAD;
            kid_ra = (p_ff == '0) ? tidx(cur_ff) : tidx(p_ff);
            wtc_ra = tidx(p_ff);
            ts_ra  = tidx(p_ff);
            blk_ra = tidx(cur_ff);
            state_in = S_E2;
         end

         S_E2: begin
            if (p_ff == '0) begin
               if (kid_rd != '0) begin
                  state_in = S_D1;
               end else begin
                  cur_in   = '0;
                  state_in = S_RESP;
               end
            end else begin
               step_req.a          = CNT_W'(kid_rd);
               step_req.up         = 1'b0;
               step_req.floor_zero = 1'b1;
               kid_we = 1'b1; kid_wa = tidx(p_ff); kid_wd = step_y[TID_W-1:0];
               hold_in   = wtc_rd;
               clrblk_in = (ts_rd == TS_JOIN) && blk_rd;
               decw_in   = ((ts_rd == TS_JOIN) && blk_rd) || (ts_rd == TS_JOINALL);
               wake_in   = ((ts_rd == TS_JOIN) && blk_rd) ||
                           ((ts_rd == TS_JOINALL) && (wtc_rd == TID_W'(1)));
               state_in  = S_E3;
            end
         end

         S_E3: begin
            step_req.a          = CNT_W'(hold_ff);
            step_req.up         = 1'b0;
            step_req.floor_zero = 1'b1;
            if (decw_ff) begin
               wtc_we = 1'b1; wtc_wa = tidx(p_ff); wtc_wd = step_y[TID_W-1:0];
            end
            if (clrblk_ff) begin
               blk_we = 1'b1; blk_wa = tidx(cur_ff); blk_wd = 1'b0;
            end
            if (wake_ff) begin
               push_en = 1'b1;
               push_id = p_ff;
               ts_we = 1'b1; ts_wa = tidx(p_ff); ts_wd = TS_READY;
            end
            state_in = S_D1;
         end

         // join one child
         S_J1: begin
            if ((tgt_ff == '0) || (tgt_ff > TID_W'(MAX_THREADS)) || !tgt_ok_ff) begin
               status_in = ST_REFUSED;
               state_in  = S_RESP;
            end else begin
               ts_ra    = tidx(tgt_ff);
               par_ra   = tidx(tgt_ff);
               state_in = S_J2;
            end
         end

         S_J2: begin
            if (ts_rd == TS_DEAD) begin
               state_in = S_RESP;
            end else if (par_rd != cur_ff) begin
               status_in = ST_REFUSED;
               state_in  = S_RESP;
            end else begin
               ts_we = 1'b1;  ts_wa = tidx(cur_ff); ts_wd = TS_JOIN;
               blk_we = 1'b1; blk_wa = tidx(tgt_ff); blk_wd = 1'b1;
               wtc_ra = tidx(cur_ff);
               state_in = S_J3;
            end
         end

         S_J3: begin
            step_req.a  = CNT_W'(wtc_rd);
            step_req.up = 1'b1;
            wtc_we = 1'b1; wtc_wa = tidx(cur_ff); wtc_wd = step_y[TID_W-1:0];
            state_in = S_D1;
         end

         // join all children
         S_JA1: begin
            kid_ra   = tidx(cur_ff);
            state_in = S_JA2;
         end

         S_JA2: begin
            if (kid_rd != '0) begin
               ts_we = 1'b1;  ts_wa = tidx(cur_ff); ts_wd = TS_JOINALL;
               wtc_we = 1'b1; wtc_wa = tidx(cur_ff); wtc_wd = kid_rd;
               state_in = S_D1;
            end else begin
               state_in = S_RESP;
            end
         end

         // signal: unlink the first waiter and make it ready
         S_SIG2: begin
            sem_we      = 1'b1;
            sem_first_w = wnx_rd;
            if (wnx_rd == '0) begin
               sem_last_w = '0;
            end
            ts_we = 1'b1; ts_wa = tidx(aux_ff); ts_wd = TS_READY;
            push_en  = 1'b1;
            push_id  = aux_ff;
            state_in = S_RESP;
         end

         // wait: append the running thread behind the old tail
         S_W2: begin
            if (aux_ff != '0) begin
               wnx_we = 1'b1; wnx_wa = tidx(aux_ff); wnx_wd = cur_ff;
            end
            state_in = S_D1;
         end

         // dispatch the head of the ready queue
         S_D1: begin
            if (fill_ff == '0) begin
               cur_in    = '0;
               status_in = ST_DEADLOCK;
               state_in  = S_RESP;
            end else begin
               head_in  = (head_ff == TIDX_W'(MAX_THREADS - 1)) ? '0 : head_ff + 1'b1;
               fill_in  = fill_ff - 1'b1;
               state_in = S_D2;
            end
         end

         S_D2: begin
            ts_we = 1'b1; ts_wa = tidx(ring_rd); ts_wd = TS_RUN;
            cur_in   = ring_rd;
            state_in = S_RESP;
         end

         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // ready queue append at head plus fill
      ring_pos = (FILL_W + 1)'(head_ff) + (FILL_W + 1)'(fill_ff);
      if (ring_pos >= (FILL_W + 1)'(MAX_THREADS)) begin
         ring_pos = ring_pos - (FILL_W + 1)'(MAX_THREADS);
      end
      ring_wa = ring_pos[TIDX_W-1:0];
      ring_wd = push_id;
      ring_we = 1'b0;
      if (push_en && (fill_ff < FILL_W'(MAX_THREADS))) begin
         ring_we = 1'b1;
         fill_in = fill_ff + 1'b1;
      end

      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);
   end

   // sequencer state, counters and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cur_ff       <= '0;
         made_ff      <= '0;
         sems_made_ff <= '0;
         live_sems_ff <= '0;
         head_ff      <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         made_ff      <= made_in;
         sems_made_ff <= sems_made_in;
         live_sems_ff <= live_sems_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff     <= op_in;
      tgt_ff    <= tgt_in;
      si_ff     <= si_in;
      init_ff   <= init_in;
      p_ff      <= p_in;
      aux_ff    <= aux_in;
      hold_ff   <= hold_in;
      wake_ff   <= wake_in;
      decw_ff   <= decw_in;
      clrblk_ff <= clrblk_in;
      tgt_ok_ff <= tgt_ok_in;
      status_ff <= status_in;
      nid_ff    <= nid_in;
      if (rsp_load) begin
         rsp_run_ff <= cur_ff;
         rsp_nid_ff <= nid_ff;
         rsp_st_ff  <= status_ff;
      end
      if (sem_we) begin
         sem_count_ff[sem_idx] <= sem_cnt_w;
         sem_first_ff[sem_idx] <= sem_first_w;
         sem_last_ff[sem_idx]  <= sem_last_w;
      end
   end

   // checks on the sequencer and its counters
   `CTS_ASSERT_NEXT(a_busy_after_take, clock, reset, req_fire, !req_tready)
   `CTS_ASSERT_NOW(a_fill_bound, clock, reset, 1'b1, fill_ff <= FILL_W'(MAX_THREADS))
   `CTS_ASSERT_NOW(a_live_sems, clock, reset, 1'b1, live_sems_ff <= sems_made_ff)
   `CTS_ASSERT_NOW(a_idle_flag, clock, reset, rsp_tvalid,
      rsp_tdata[17] == (rsp_tdata[6:0] == 7'd0))

endmodule

`default_nettype wire
